// ===== rtl/sha512_pkg.sv =====
`default_nettype none
package sha512_pkg;

  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned LEN_POS = 112;

  typedef logic [63:0] word_t;

  // one queued item between front and back
  typedef struct packed {
    logic       finish;
    logic [6:0] fill;
    word_t      bits;
    word_t      word;
  } job_t;

  function automatic word_t round_k(input logic [6:0] idx);
    word_t k;
    case (idx)
      7'd0:  k = 64'h428a2f98d728ae22; 7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f; 7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538; 7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b; 7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242; 7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = 64'h0;
    endcase
    return k;
  endfunction

  function automatic word_t init_h(input logic [2:0] idx);
    word_t h;
    case (idx)
      3'd0: h = 64'h6a09e667f3bcc908;
      3'd1: h = 64'hbb67ae8584caa73b;
      3'd2: h = 64'h3c6ef372fe94f82b;
      3'd3: h = 64'ha54ff53a5f1d36f1;
      3'd4: h = 64'h510e527fade682d1;
      3'd5: h = 64'h9b05688c2b3e6c1f;
      3'd6: h = 64'h1f83d9abfb41bd6b;
      default: h = 64'h5be0cd19137e2179;
    endcase
    return h;
  endfunction

  function automatic word_t rotr(input word_t v, input int unsigned n);
    return (v >> n) | (v << (64 - n));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sha512_front.sv =====
`default_nettype none
// Packs bytes into big-endian words and tracks the message length.
module sha512_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_action,
  input  wire logic [7:0]        in_data_byte,
  output logic                   q_valid,
  input  wire logic              q_stall,
  output sha512_pkg::job_t       q_job
);

  logic [63:0] count_r, count_nxt;
  logic [55:0] part_r, part_nxt;
  logic        busy_r, busy_nxt;
  sha512_pkg::job_t job_r, job_nxt;
  logic        acc;
  logic [6:0]  fill;

  assign fill     = count_r[6:0];
  assign in_stall = busy_r;
  assign acc      = in_valid && !busy_r;
  assign q_valid  = busy_r;
  assign q_job    = job_r;

  // classify a beat; hold a word or a finish until the back takes it
  always_comb begin
    count_nxt = count_r;
    part_nxt  = part_r;
    busy_nxt  = busy_r;
    job_nxt   = job_r;
    if (busy_r && !q_stall) busy_nxt = 1'b0;
    if (acc) begin
      job_nxt.fill  = fill;
      job_nxt.bits  = {count_r[60:0], 3'b000};
      job_nxt.word  = {part_r, in_data_byte};
      job_nxt.finish = (in_action == sha512_pkg::ACT_FINISH);
      if (in_action == sha512_pkg::ACT_FINISH) begin
        count_nxt = 64'd0;
        busy_nxt  = 1'b1;
      end else begin
        count_nxt = count_r + 64'd1;
        part_nxt  = {part_r[47:0], in_data_byte};
        if (fill[2:0] == 3'd7) begin
          busy_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 64'd0;
      busy_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
    end
    part_r <= part_nxt;
    job_r  <= job_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/sha512_back.sv =====
`default_nettype none
// Collects words, runs the rounds one per cycle, pads, emits the digest.
module sha512_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_stall,
  input  wire sha512_pkg::job_t  q_job,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [63:0]            out_digest_word,
  output logic [2:0]             out_word_index,
  output logic                   out_last_word
);

  localparam logic [2:0] ST_COLLECT = 3'd0;
  localparam logic [2:0] ST_ROUND   = 3'd1;
  localparam logic [2:0] ST_ADD     = 3'd2;
  localparam logic [2:0] ST_PAD     = 3'd3;
  localparam logic [2:0] ST_EMIT    = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic [63:0] w_r [16];
  logic [63:0] w_nxt [16];
  logic [63:0] h_r [8];
  logic [63:0] h_nxt [8];
  logic [63:0] v_r [8];
  logic [63:0] v_nxt [8];
  logic [3:0]  wcnt_r, wcnt_nxt;
  logic [6:0]  rnd_r, rnd_nxt;
  logic        fin_r, fin_nxt;    // compression belongs to a finish
  logic        spill_r, spill_nxt; // one more padded block follows
  logic [63:0] bits_r, bits_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic [63:0] t1, t2, s0, s1, wn, padw;
  logic [63:0] tail;
  logic [2:0]  tb;
  integer i;

  assign q_stall = (st_r != ST_COLLECT);
  assign out_valid = (st_r == ST_EMIT);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  // partial last word: kept bytes, then the pad byte, then zeros
  assign tb = q_job.fill[2:0];
  always_comb begin
    tail = 64'd0;
    for (i = 0; i < 8; i++) begin
      if (i[2:0] < tb) tail[63-8*i -: 8] = q_job.word[8*(tb-i[2:0])+7 -: 8];
      else if (i[2:0] == tb) tail[63-8*i -: 8] = sha512_pkg::PAD_BYTE;
    end
  end

  // round datapath and message schedule step
  always_comb begin
    s1 = sha512_pkg::rotr(v_r[4], 14) ^ sha512_pkg::rotr(v_r[4], 18)
       ^ sha512_pkg::rotr(v_r[4], 41);
    s0 = sha512_pkg::rotr(v_r[0], 28) ^ sha512_pkg::rotr(v_r[0], 34)
       ^ sha512_pkg::rotr(v_r[0], 39);
    t1 = v_r[7] + s1 + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + sha512_pkg::round_k(rnd_r) + w_r[0];
    t2 = s0 + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    wn = (sha512_pkg::rotr(w_r[14], 19) ^ sha512_pkg::rotr(w_r[14], 61)
       ^ (w_r[14] >> 6)) + w_r[9]
       + (sha512_pkg::rotr(w_r[1], 1) ^ sha512_pkg::rotr(w_r[1], 8)
       ^ (w_r[1] >> 7)) + w_r[0];
    padw = (wcnt_r == 4'd15) ? bits_r : 64'd0;
  end

  always_comb begin
    st_nxt = st_r;
    wcnt_nxt = wcnt_r;
    rnd_nxt = rnd_r;
    fin_nxt = fin_r;
    spill_nxt = spill_r;
    bits_nxt = bits_r;
    oidx_nxt = oidx_r;
    for (int j = 0; j < 16; j++) w_nxt[j] = w_r[j];
    for (int j = 0; j < 8; j++) begin
      h_nxt[j] = h_r[j];
      v_nxt[j] = v_r[j];
    end
    case (st_r)
      ST_COLLECT: begin
        if (q_valid) begin
          if (!q_job.finish) begin
            w_nxt[wcnt_r] = q_job.word;
            wcnt_nxt = wcnt_r + 4'd1;
            fin_nxt = 1'b0;
            if (wcnt_r == 4'd15) begin
              st_nxt = ST_ROUND;
              rnd_nxt = 7'd0;
              for (int j = 0; j < 8; j++) v_nxt[j] = h_r[j];
            end
          end else begin
            w_nxt[wcnt_r] = tail;
            wcnt_nxt = wcnt_r + 4'd1;
            bits_nxt = q_job.bits;
            fin_nxt = 1'b1;
            spill_nxt = (q_job.fill >= 7'(sha512_pkg::LEN_POS));
            st_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // zero fill; length in the last word unless spill_r is set
        if (wcnt_r != 4'd0) begin
          w_nxt[wcnt_r] = (spill_r) ? 64'd0 : padw;
          wcnt_nxt = wcnt_r + 4'd1;
        end
        if (wcnt_r == 4'd15 || wcnt_r == 4'd0) begin
          st_nxt = ST_ROUND;
          rnd_nxt = 7'd0;
          wcnt_nxt = 4'd0;
          for (int j = 0; j < 8; j++) v_nxt[j] = h_r[j];
        end
      end
      ST_ROUND: begin
        for (int j = 0; j < 15; j++) w_nxt[j] = w_r[j+1];
        w_nxt[15] = wn;
        v_nxt[7] = v_r[6]; v_nxt[6] = v_r[5]; v_nxt[5] = v_r[4];
        v_nxt[4] = v_r[3] + t1;
        v_nxt[3] = v_r[2]; v_nxt[2] = v_r[1]; v_nxt[1] = v_r[0];
        v_nxt[0] = t1 + t2;
        rnd_nxt = rnd_r + 7'd1;
        if (rnd_r == 7'(sha512_pkg::NUM_ROUNDS - 1)) st_nxt = ST_ADD;
      end
      ST_ADD: begin
        for (int j = 0; j < 8; j++) h_nxt[j] = h_r[j] + v_r[j];
        wcnt_nxt = 4'd0;
        if (!fin_r) st_nxt = ST_COLLECT;
        else if (spill_r) begin
          // second padded block: all zero but the length
          spill_nxt = 1'b0;
          for (int j = 0; j < 15; j++) w_nxt[j] = 64'd0;
          w_nxt[15] = bits_r;
          st_nxt = ST_ROUND;
          rnd_nxt = 7'd0;
          for (int j = 0; j < 8; j++) v_nxt[j] = h_r[j] + v_r[j];
        end else begin
          st_nxt = ST_EMIT;
          oidx_nxt = 3'd0;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            st_nxt = ST_COLLECT;
            for (int j = 0; j < 8; j++) h_nxt[j] = sha512_pkg::init_h(3'(j));
          end
        end
      end
      default: st_nxt = ST_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_COLLECT;
      wcnt_r <= 4'd0;
      for (int j = 0; j < 8; j++) h_r[j] <= sha512_pkg::init_h(3'(j));
    end else begin
      st_r <= st_nxt;
      wcnt_r <= wcnt_nxt;
      for (int j = 0; j < 8; j++) h_r[j] <= h_nxt[j];
    end
    rnd_r <= rnd_nxt;
    fin_r <= fin_nxt;
    spill_r <= spill_nxt;
    bits_r <= bits_nxt;
    oidx_r <= oidx_nxt;
    for (int j = 0; j < 16; j++) w_r[j] <= w_nxt[j];
    for (int j = 0; j < 8; j++) v_r[j] <= v_nxt[j];
  end

endmodule
`default_nettype wire

// ===== rtl/sha512_hash_stream.sv =====
`default_nettype none
// channel | ports                                          | direction
// input   | in_valid in_stall in_action in_data_byte       | beat in
// result  | out_valid out_stall out_digest_word            | beat out
//         | out_word_index out_last_word                   |
// Absorb beats are taken while nothing is queued; the eighth byte
// of a word stalls the input until the back takes the queued word.
// A full block uses the single shared round unit for its rounds and
// the add step; the front takes up to eight more bytes, then stalls.
// A finish pads the last block and runs one or two compressions, then
// 8 result beats. rst_n clears control and loads the initial hash;
// out_stall holds a beat.
module sha512_hash_stream (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);

  logic q_valid, q_stall;
  sha512_pkg::job_t q_job;

  sha512_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_action, .in_data_byte,
    .q_valid, .q_stall, .q_job
  );

  sha512_back u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_job,
    .out_valid, .out_stall, .out_digest_word, .out_word_index, .out_last_word
  );

endmodule
`default_nettype wire
